// ===== rtl/lbpr_pkg.sv =====
// Shared types and codes for the LSB-first bit packer and reader.
`timescale 1ns / 1ps
`default_nettype none
package lbpr_pkg;

    localparam int STORE_BYTES_DEF = 1024;
    localparam int MAX_BITS        = 64;

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_PAD    = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_SET    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_APPEND = 3'd0,
        K_PAD    = 3'd1,
        K_READ   = 3'd2,
        K_SET    = 3'd3,
        K_CLEAR  = 3'd4,
        K_NOP    = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] bits_in;
        logic [6:0]  bit_count;
        logic [12:0] bit_position;
    } t_in_item;

    typedef struct packed {
        logic [63:0] read_value;
        logic [6:0]  bits_read;
        logic [1:0]  status;
        logic [13:0] length_bits;
        logic [10:0] length_bytes;
        logic [13:0] read_position;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic        range_err;
        logic [63:0] data;
        logic [6:0]  count;
        logic [12:0] pos;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/lbpr_front.sv =====
// Front end: decodes incoming transactions and queues them as commands.
`timescale 1ns / 1ps
`default_nettype none
module lbpr_front
    import lbpr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  wire logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_wr;

    always_comb begin
        w_cmd.data      = i_item.bits_in;
        w_cmd.count     = i_item.bit_count;
        w_cmd.pos       = i_item.bit_position;
        w_cmd.range_err = 1'b0;
        unique case (i_item.action)
            ACT_APPEND: begin
                w_cmd.kind      = K_APPEND;
                w_cmd.range_err = (32'(i_item.bit_count) > MAX_BITS);
            end
            ACT_PAD:   w_cmd.kind = K_PAD;
            ACT_READ: begin
                w_cmd.kind      = K_READ;
                w_cmd.range_err = (32'(i_item.bit_count) > MAX_BITS);
            end
            ACT_SET:   w_cmd.kind = K_SET;
            ACT_CLEAR: w_cmd.kind = K_CLEAR;
            default:   w_cmd.kind = K_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_wr        = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(i_cmd_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lbpr_back.sv =====
// Back end: byte store, length and cursor, command execution and result register.
`timescale 1ns / 1ps
`default_nettype none
module lbpr_back
    import lbpr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output t_out_item o_result,
    output logic      o_empty,
    input  wire logic i_pop
);

    localparam int CAP = STORE_BYTES * 8;
    localparam int LW  = $clog2(CAP + 1);
    localparam int LX  = LW + 1;
    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_RD    = 5'b00100,
        S_WR    = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    function automatic logic [63:0] f_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

    logic [7:0]  r_mem [STORE_BYTES];
    logic [7:0]  r_rdata;

    t_state      r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_cur, n_cur;
    logic [AW-1:0] r_base, n_base;
    logic [2:0]  r_off, n_off;
    logic [3:0]  r_nb, n_nb;
    logic [3:0]  r_k, n_k;
    logic [71:0] r_shift, n_shift;
    logic [71:0] r_acc, n_acc;
    logic [6:0]  r_got, n_got;
    logic [1:0]  r_status, n_status;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic          w_re;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata;
    logic [6:0]    w_cnt;
    logic [63:0]   w_data;
    logic [LX-1:0] w_sum;
    logic [LX-1:0] w_avail;
    logic [6:0]    w_got;

    assign w_addr = AW'(32'(r_base) + 32'(r_k));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_cur       = r_cur;
        n_base      = r_base;
        n_off       = r_off;
        n_nb        = r_nb;
        n_k         = r_k;
        n_shift     = r_shift;
        n_acc       = r_acc;
        n_got       = r_got;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_cmd_pop   = 1'b0;
        w_re        = 1'b0;
        w_we        = 1'b0;
        w_wdata     = r_shift[7:0];

        w_cnt = r_cmd.count;
        w_data = r_cmd.data;
        if (r_cmd.kind == K_PAD) begin
            w_cnt  = (r_len[2:0] == 3'd0) ? 7'd0 : 7'(4'd8 - {1'b0, r_len[2:0]});
            w_data = '0;
        end
        w_sum   = LX'(r_len) + LX'(w_cnt);
        w_avail = LX'(r_len) - LX'(r_cur);
        w_got   = (LX'(r_cmd.count) <= w_avail) ? r_cmd.count : 7'(w_avail);

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_SETUP;
                end
            end
            S_SETUP: begin
                n_status = ST_OK;
                n_acc    = '0;
                n_got    = 7'd0;
                n_off    = 3'd0;
                n_k      = 4'd0;
                n_nb     = 4'd0;
                n_state  = S_FIN;
                case (r_cmd.kind)
                    K_APPEND, K_PAD: begin
                        if (r_cmd.range_err && r_cmd.kind == K_APPEND) begin
                            n_status = ST_RANGE;
                        end else if (w_sum > LX'(CAP)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_base  = AW'(r_len >> 3);
                            n_off   = r_len[2:0];
                            n_shift = 72'(w_data & f_mask(w_cnt)) << r_len[2:0];
                            n_nb    = 4'((8'(r_len[2:0]) + 8'(w_cnt) + 8'd7) >> 3);
                            n_len   = LW'(w_sum);
                            if (w_cnt != 7'd0) begin
                                n_state = S_RD;
                            end
                        end
                    end
                    K_READ: begin
                        if (r_cmd.range_err) begin
                            n_status = ST_RANGE;
                        end else begin
                            if (w_got != r_cmd.count) begin
                                n_status = ST_RANGE;
                            end
                            n_got  = w_got;
                            n_base = AW'(r_cur >> 3);
                            n_off  = r_cur[2:0];
                            n_nb   = 4'((8'(r_cur[2:0]) + 8'(w_got) + 8'd7) >> 3);
                            n_cur  = r_cur + LW'(w_got);
                            if (w_got != 7'd0) begin
                                n_state = S_RD;
                            end
                        end
                    end
                    K_SET: begin
                        if (LX'(r_cmd.pos) >= LX'(r_len)) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_base  = AW'(r_cmd.pos >> 3);
                            n_off   = r_cmd.pos[2:0];
                            n_nb    = 4'd1;
                            n_state = S_RD;
                        end
                    end
                    K_CLEAR: begin
                        n_len = '0;
                        n_cur = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                case (r_cmd.kind)
                    K_READ: begin
                        n_acc[8*r_k +: 8] = r_rdata;
                    end
                    K_SET: begin
                        w_we    = 1'b1;
                        w_wdata = r_rdata | (8'd1 << r_off);
                    end
                    default: begin
                        w_we = 1'b1;
                        if (r_k == 4'd0) begin
                            w_wdata = (r_rdata & ((8'd1 << r_off) - 8'd1)) | r_shift[7:0];
                        end
                        n_shift = r_shift >> 8;
                    end
                endcase
                n_k     = r_k + 4'd1;
                n_state = (r_k + 4'd1 == r_nb) ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (!r_out_valid || i_pop) begin
                    n_out.read_value    = 64'(r_acc >> r_off) & f_mask(r_got);
                    n_out.bits_read     = r_got;
                    n_out.status        = r_status;
                    n_out.length_bits   = 14'(r_len);
                    n_out.length_bytes  = 11'((32'(r_len) + 32'd7) >> 3);
                    n_out.read_position = 14'(r_cur);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_base   <= n_base;
        r_off    <= n_off;
        r_nb     <= n_nb;
        r_k      <= n_k;
        r_shift  <= n_shift;
        r_acc    <= n_acc;
        r_got    <= n_got;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/lsb_first_bit_packer_reader_unit.sv =====
// Top level of the LSB-first bit packer and reader.
`timescale 1ns / 1ps
`default_nettype none
// Holds a bit string packed least significant bit first in a byte store of
// STORE_BYTES bytes and answers every transaction with one result. A two-entry
// command queue sits in front of the execution engine, so up to two
// transactions are taken while one is being carried out and its result waits.
// The engine fetches a command, sets it up, reads and then writes back each
// byte of the single-port byte memory that it touches (up to nine bytes; a
// read captures each byte instead of writing it back) and posts the result
// once the result register is free. Pad when aligned, clear, out-of-range and
// full cases touch no byte. The store needs no clearing pass.
module lsb_first_bit_packer_reader_unit
    import lbpr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_item,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_result
);

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    lbpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    lbpr_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command taken from empty queue");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.status != 2'd3)
        else $error("undefined status code");

    a_read_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.read_value >> o_result.bits_read) == 64'd0)
        else $error("read value has bits above bits_read");

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.bits_read <= 7'd64)
        else $error("bits_read above limit");
`endif

endmodule
`default_nettype wire

// ===== bench/lbpr_checker.sv =====
// Checker for the bit packer: predicts each result from accepted items and compares.
`timescale 1ns / 1ps
`default_nettype none
module lbpr_checker
    import lbpr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire logic      i_full,
    input  wire t_in_item  i_item,
    input  wire logic      i_empty,
    input  wire logic      i_pop,
    input  wire t_out_item i_result,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_len_bits
);
    localparam int CAP_BITS = STORE_BYTES_DEF * 8;

    logic        stream_bits [0:CAP_BITS-1];
    int unsigned wlen;
    int unsigned rcur;
    t_out_item   expected_results [$];

    task pack_step(input t_in_item it, output t_out_item r);
        int unsigned n;
        int unsigned got;
        logic [63:0] value;
        logic [1:0]  st;
        n     = it.bit_count;
        got   = 0;
        value = '0;
        st    = ST_OK;
        case (it.action)
            ACT_APPEND: begin
                if (n > MAX_BITS) begin
                    st = ST_RANGE;
                end else if (wlen + n > CAP_BITS) begin
                    st = ST_FULL;
                end else begin
                    for (int i = 0; i < n; i++) stream_bits[wlen + i] = it.bits_in[i];
                    wlen += n;
                end
            end
            ACT_PAD: begin
                while ((wlen % 8) != 0 && wlen < CAP_BITS) begin
                    stream_bits[wlen] = 1'b0;
                    wlen++;
                end
            end
            ACT_READ: begin
                if (n > MAX_BITS) begin
                    st = ST_RANGE;
                end else begin
                    while (got < n && rcur < wlen) begin
                        value[got] = stream_bits[rcur];
                        rcur++;
                        got++;
                    end
                    if (got < n) st = ST_RANGE;
                end
            end
            ACT_SET: begin
                if (it.bit_position >= wlen) st = ST_RANGE;
                else stream_bits[it.bit_position] = 1'b1;
            end
            ACT_CLEAR: begin
                wlen = 0;
                rcur = 0;
            end
            default: ;
        endcase
        r.read_value    = value;
        r.bits_read     = got[6:0];
        r.status        = st;
        r.length_bits   = wlen[13:0];
        r.length_bytes  = 11'((wlen + 7) >> 3);
        r.read_position = rcur[13:0];
    endtask

    always_ff @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            wlen = 0;
            rcur = 0;
            o_fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10) $display("result with none expected: %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_result !== exp_r) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch at %0t: value %h/%h count %0d/%0d status %0d/%0d",
                                     $realtime, exp_r.read_value, i_result.read_value,
                                     exp_r.bits_read, i_result.bits_read,
                                     exp_r.status, i_result.status);
                            $display("  len %0d/%0d bytes %0d/%0d cursor %0d/%0d",
                                     exp_r.length_bits, i_result.length_bits,
                                     exp_r.length_bytes, i_result.length_bytes,
                                     exp_r.read_position, i_result.read_position);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                pack_step(i_item, exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end

    assign o_pending  = expected_results.size();
    assign o_len_bits = wlen;
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench top: drives items and pops results of the bit packer, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import lbpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  i_item = '0;
    t_out_item o_result;
    int        fail_count;
    int        pending;
    int        len_bits;
    bit        idle_on = 1'b1;
    int        pop_hold = 0;
    int        quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lsb_first_bit_packer_reader_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    lbpr_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_item      (i_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_len_bits  (len_bits)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pop_hold <= $urandom_range(0, 2);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send(input logic [2:0] act, input logic [63:0] data, input logic [6:0] cnt,
              input logic [12:0] bpos);
        t_in_item it;
        it = '{action: act, bits_in: data, bit_count: cnt, bit_position: bpos};
        if (idle_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    task send_random(input bit filling);
        int          pick;
        logic [2:0]  act;
        logic [6:0]  cnt;
        logic [12:0] bpos;
        pick = $urandom_range(0, 99);
        cnt  = 7'($urandom_range(0, 64));
        if ($urandom_range(0, 29) == 0) cnt = 7'($urandom_range(65, 127));
        if (filling && pick < 75) begin
            act = ACT_APPEND;
            cnt = ($urandom_range(0, 3) == 0) ? cnt : 7'd64;
        end else if (pick < 45) act = ACT_APPEND;
        else if (pick < 53) act = ACT_PAD;
        else if (pick < 75) act = ACT_READ;
        else if (pick < 90) act = ACT_SET;
        else if (pick < 94 && !filling) act = ACT_CLEAR;
        else act = 3'($urandom_range(5, 7));
        if (len_bits > 0 && $urandom_range(0, 3) != 0) bpos = 13'($urandom_range(0, len_bits - 1));
        else bpos = 13'($urandom_range(0, 8191));
        send(act, {$urandom, $urandom}, cnt, bpos);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 13'd0);
        send(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 13'd0);
        send(ACT_APPEND, 64'h0, 7'd1, 13'd0);
        send(ACT_PAD, 64'h0, 7'd0, 13'd0);
        send(ACT_PAD, 64'h0, 7'd0, 13'd0);
        send(ACT_APPEND, 64'h0, 7'd64, 13'd0);
        send(ACT_APPEND, 64'hA5A5_5A5A_0123_4567, 7'd3, 13'd0);
        send(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 13'd0);
        send(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd65, 13'd0);
        send(ACT_READ, 64'h0, 7'd0, 13'd0);
        send(ACT_READ, 64'h0, 7'd64, 13'd0);
        send(ACT_READ, 64'h0, 7'd127, 13'd0);
        send(ACT_SET, 64'h0, 7'd0, 13'd0);
        send(ACT_SET, 64'h0, 7'd0, 13'd140);
        send(ACT_SET, 64'h0, 7'd0, 13'd8191);
        send(ACT_SET, 64'h0, 7'd0, 13'd80);
        send(ACT_READ, 64'h0, 7'd64, 13'd0);
        send(ACT_READ, 64'h0, 7'd10, 13'd0);
        send(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 13'd8191);
        send(3'd6, 64'h0, 7'd0, 13'd0);
        send(3'd7, 64'h0, 7'd1, 13'd1);
        send(ACT_CLEAR, 64'h0, 7'd0, 13'd0);
        send(ACT_READ, 64'h0, 7'd1, 13'd0);
        send(ACT_SET, 64'h0, 7'd0, 13'd0);

        repeat (250) send_random(1'b0);
        repeat (200) send_random(1'b1);

        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        repeat (80) send_random(1'b1);
        repeat (100) send_random(1'b0);
        idle_on = 1'b0;
        repeat (120) send_random(1'b0);
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lbpr_pkg.sv
rtl/lbpr_front.sv
rtl/lbpr_back.sv
rtl/lsb_first_bit_packer_reader_unit.sv
bench/lbpr_checker.sv
bench/tb_top.sv
